// ===== hw/rtl/pcs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the pair coherence spatial spectrum block.
// Used by the multiplier, divider, top level and bench; depends on nothing.
package pcs_pkg;

    localparam int AUTO_W  = 32;
    localparam int STEER_W = 16;
    localparam int SUM_W   = 40;
    localparam int MUL_A_W = 37;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int P_W     = 49;
    localparam int RATIO_W = 37;
    localparam int DVD_W   = 55;
    localparam int DVS_W   = 37;
    localparam int TERM_W  = 57;

    localparam logic signed [MUL_B_W-1:0] Q14_ONE = 18'sd16384;
    localparam logic signed [SUM_W-1:0]   SUM_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0]   SUM_MIN = 40'sh80_0000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_PREP,
        ST_MUL_C,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_TERM,
        ST_ACC
    } pcs_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pcs_div_status_t;

endpackage

// ===== hw/rtl/pair_coherence_spatial_spectrum.sv =====
`timescale 1ns / 1ps
// Top level of the pair coherence spatial spectrum accumulator.
// Depends on pcs_pkg, pcs_mul and pcs_div.
// An item is accepted in the idle state and the next one only once the sequencer is idle again;
// with a zero divisor the 55-step radix-2 divider is skipped; one item is worked on at a time.
// A sum is registered in the accumulate state of its last item, or later while an earlier sum is
// still stalled at the output. Reset clears the sum, flags, sequencer and out_valid.
module pair_coherence_spatial_spectrum (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [pcs_pkg::AUTO_W-1:0]   auto_first_re,
    input  logic signed [pcs_pkg::AUTO_W-1:0]   auto_second_re,
    input  logic signed [pcs_pkg::AUTO_W-1:0]   cross_re,
    input  logic signed [pcs_pkg::AUTO_W-1:0]   cross_im,
    input  logic signed [pcs_pkg::STEER_W-1:0]  steer_re,
    input  logic signed [pcs_pkg::STEER_W-1:0]  steer_im,
    input  logic signed [pcs_pkg::STEER_W-1:0]  coherence,
    input  logic                                last_pair,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [pcs_pkg::SUM_W-1:0]    spectrum,
    output logic                                divide_by_zero,
    output logic                                saturated
);
    import pcs_pkg::*;

    pcs_state_t state_reg, state_next;

    logic signed [AUTO_W:0]    tr_reg, tr_next;
    logic signed [AUTO_W-1:0]  cr_reg, cr_next;
    logic signed [AUTO_W-1:0]  ci_reg, ci_next;
    logic signed [STEER_W-1:0] sr_reg, sr_next;
    logic signed [STEER_W-1:0] si_reg, si_next;
    logic signed [STEER_W-1:0] c_reg, c_next;
    logic                      last_reg, last_next;
    logic signed [P_W-1:0]     p_reg, p_next;
    logic signed [RATIO_W-1:0] num_reg, num_next;
    logic signed [RATIO_W-1:0] den_reg, den_next;
    logic                      zden_reg, zden_next;
    logic                      topneg_reg, topneg_next;
    logic                      qneg_reg, qneg_next;
    logic signed [SUM_W-1:0]   term_reg, term_next;
    logic                      tsat_reg, tsat_next;

    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic                      zseen_reg, zseen_next;
    logic                      sseen_reg, sseen_next;
    logic                      ovalid_reg, ovalid_next;
    logic signed [SUM_W-1:0]   ospec_reg, ospec_next;
    logic                      ozd_reg, ozd_next;
    logic                      osat_reg, osat_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic                      div_start;
    logic [DVD_W-1:0]          div_dividend;
    logic [DVS_W-1:0]          div_divisor;
    logic [DVD_W-1:0]          quotient;
    pcs_div_status_t           div_status;

    logic                      accept;
    logic                      out_busy;
    logic signed [P_W-1:0]     p_diff;
    logic signed [P_W-15:0]    t_val;
    logic signed [RATIO_W-1:0] tr_ext;
    logic signed [RATIO_W-1:0] t2_ext;
    logic signed [PROD_W:0]    top;
    logic signed [PROD_W:0]    top_neg;
    logic signed [RATIO_W-1:0] den_neg;
    logic signed [TERM_W-1:0]  q_pos;
    logic signed [TERM_W-1:0]  q_signed;
    logic signed [MUL_B_W-1:0] k_off;
    logic signed [TERM_W-1:0]  term_full;
    logic signed [SUM_W:0]     sum_full;
    logic signed [SUM_W-1:0]   sum_clamped;
    logic                      sum_hit;

    pcs_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    pcs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quotient),
        .status   (div_status)
    );

    assign accept   = in_valid && !in_stall;
    assign out_busy = ovalid_reg && out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A:     state_next = ST_MUL_B;
            ST_MUL_B:     state_next = ST_PREP;
            ST_PREP:      state_next = ST_MUL_C;
            ST_MUL_C:     state_next = ST_DIV_START;
            ST_DIV_START: state_next = (den_reg == '0) ? ST_TERM : ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_status.done)
                begin
                    state_next = ST_TERM;
                end
            end
            ST_TERM:      state_next = ST_ACC;
            ST_ACC:
            begin
                if (!(last_reg && out_busy))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        div_start = 1'b0;
        mul_a     = RATIO_W'(cr_reg);
        mul_b     = MUL_B_W'(sr_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_MUL_A:
            begin
                mul_a = RATIO_W'(cr_reg);
                mul_b = MUL_B_W'(sr_reg);
            end
            ST_MUL_B:
            begin
                mul_a = RATIO_W'(ci_reg);
                mul_b = MUL_B_W'(si_reg);
            end
            ST_MUL_C:
            begin
                mul_a = num_reg;
                mul_b = Q14_ONE - MUL_B_W'(c_reg);
            end
            ST_DIV_START:
            begin
                div_start = (den_reg != '0);
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign p_diff  = p_reg - prod[P_W-1:0];
    assign t_val   = p_diff[P_W-1:14];
    assign tr_ext  = RATIO_W'(tr_reg);
    assign t2_ext  = RATIO_W'($signed({t_val, 1'b0}));
    assign top     = {prod, 1'b0};
    assign top_neg = -top;
    assign den_neg = -den_reg;

    assign div_dividend = top[PROD_W] ? top_neg[DVD_W-1:0] : top[DVD_W-1:0];
    assign div_divisor  = den_reg[RATIO_W-1] ? den_neg : den_reg;

    assign q_pos     = TERM_W'({1'b0, quotient});
    assign q_signed  = qneg_reg ? -q_pos : q_pos;
    assign k_off     = (Q14_ONE + MUL_B_W'(c_reg)) <<< 1;
    assign term_full = q_signed - TERM_W'(k_off);

    assign sum_full = (SUM_W + 1)'(sum_reg) + (SUM_W + 1)'(term_reg);
    assign sum_hit  = sum_full[SUM_W] != sum_full[SUM_W-1];
    assign sum_clamped = sum_hit ? (sum_full[SUM_W] ? SUM_MIN : SUM_MAX)
                                 : sum_full[SUM_W-1:0];

    always_comb
    begin
        tr_next     = tr_reg;
        cr_next     = cr_reg;
        ci_next     = ci_reg;
        sr_next     = sr_reg;
        si_next     = si_reg;
        c_next      = c_reg;
        last_next   = last_reg;
        p_next      = p_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        zden_next   = zden_reg;
        topneg_next = topneg_reg;
        qneg_next   = qneg_reg;
        term_next   = term_reg;
        tsat_next   = tsat_reg;
        sum_next    = sum_reg;
        zseen_next  = zseen_reg;
        sseen_next  = sseen_reg;
        ovalid_next = ovalid_reg && out_stall;
        ospec_next  = ospec_reg;
        ozd_next    = ozd_reg;
        osat_next   = osat_reg;

        if (accept)
        begin
            tr_next   = (AUTO_W + 1)'(auto_first_re) + (AUTO_W + 1)'(auto_second_re);
            cr_next   = cross_re;
            ci_next   = cross_im;
            sr_next   = steer_re;
            si_next   = steer_im;
            c_next    = coherence;
            last_next = last_pair;
        end

        case (state_reg)
            ST_MUL_B:
            begin
                p_next = prod[P_W-1:0];
            end
            ST_PREP:
            begin
                num_next = tr_ext + t2_ext;
                den_next = tr_ext - t2_ext;
            end
            ST_DIV_START:
            begin
                zden_next   = (den_reg == '0);
                topneg_next = top[PROD_W];
                qneg_next   = top[PROD_W] ^ den_reg[RATIO_W-1];
            end
            ST_TERM:
            begin
                if (zden_reg)
                begin
                    term_next = topneg_reg ? SUM_MIN : SUM_MAX;
                    tsat_next = 1'b1;
                end
                else if (term_full > TERM_W'(SUM_MAX))
                begin
                    term_next = SUM_MAX;
                    tsat_next = 1'b1;
                end
                else if (term_full < TERM_W'(SUM_MIN))
                begin
                    term_next = SUM_MIN;
                    tsat_next = 1'b1;
                end
                else
                begin
                    term_next = term_full[SUM_W-1:0];
                    tsat_next = 1'b0;
                end
            end
            ST_ACC:
            begin
                if (!last_reg)
                begin
                    sum_next   = sum_clamped;
                    zseen_next = zseen_reg || zden_reg;
                    sseen_next = sseen_reg || tsat_reg || sum_hit;
                end
                else if (!out_busy)
                begin
                    ovalid_next = 1'b1;
                    ospec_next  = sum_clamped;
                    ozd_next    = zseen_reg || zden_reg;
                    osat_next   = sseen_reg || tsat_reg || sum_hit;
                    sum_next    = '0;
                    zseen_next  = 1'b0;
                    sseen_next  = 1'b0;
                end
            end
            default:
            begin
                sum_next = sum_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            sum_reg    <= '0;
            zseen_reg  <= 1'b0;
            sseen_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sum_reg    <= sum_next;
            zseen_reg  <= zseen_next;
            sseen_reg  <= sseen_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tr_reg     <= tr_next;
        cr_reg     <= cr_next;
        ci_reg     <= ci_next;
        sr_reg     <= sr_next;
        si_reg     <= si_next;
        c_reg      <= c_next;
        last_reg   <= last_next;
        p_reg      <= p_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        zden_reg   <= zden_next;
        topneg_reg <= topneg_next;
        qneg_reg   <= qneg_next;
        term_reg   <= term_next;
        tsat_reg   <= tsat_next;
        ospec_reg  <= ospec_next;
        ozd_reg    <= ozd_next;
        osat_reg   <= osat_next;
    end

    assign out_valid      = ovalid_reg;
    assign spectrum       = ospec_reg;
    assign divide_by_zero = ozd_reg;
    assign saturated      = osat_reg;

endmodule

// ===== hw/rtl/pcs_mul.sv =====
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Depends on pcs_pkg for the operand widths.
module pcs_mul (
    input  logic                                clk,
    input  logic signed [pcs_pkg::MUL_A_W-1:0]  a,
    input  logic signed [pcs_pkg::MUL_B_W-1:0]  b,
    output logic signed [pcs_pkg::PROD_W-1:0]   prod
);
    import pcs_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(a) * PROD_W'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== hw/rtl/pcs_div.sv =====
`timescale 1ns / 1ps
// Unsigned radix-2 restoring divider, one quotient bit per cycle.
// Depends on pcs_pkg for widths and the status struct.
module pcs_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [pcs_pkg::DVD_W-1:0]         dividend,
    input  logic [pcs_pkg::DVS_W-1:0]         divisor,
    output logic [pcs_pkg::DVD_W-1:0]         quotient,
    output pcs_pkg::pcs_div_status_t          status
);
    import pcs_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           fits;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = '0;
            quo_next   = dividend;
            dvs_next   = divisor;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next   = {quo_reg[DVD_W-2:0], fits};
            count_next = count_reg + 1'b1;
            if (count_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== verif/tb_pair_coherence_spatial_spectrum.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pair_coherence_spatial_spectrum: directed rows, then random bins,
// each compared with a table value if typed, else a cycle-free predictor of bin sum and flags.
// Depends on pcs_pkg and the RTL of the block.
module tb_pair_coherence_spatial_spectrum;
    import pcs_pkg::*;

    typedef struct packed {
        logic signed [AUTO_W-1:0]  auto_first_re;
        logic signed [AUTO_W-1:0]  auto_second_re;
        logic signed [AUTO_W-1:0]  cross_re;
        logic signed [AUTO_W-1:0]  cross_im;
        logic signed [STEER_W-1:0] steer_re;
        logic signed [STEER_W-1:0] steer_im;
        logic signed [STEER_W-1:0] coherence;
        logic                      last_pair;
    } pair_item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] spectrum;
        logic                    divide_by_zero;
        logic                    saturated;
    } bin_result_t;

    typedef struct packed {
        pair_item_t  item;
        logic        typed;
        bin_result_t want;
    } directed_row_t;

    localparam int N_TOTAL = 1650;
    localparam int QUIET_TAIL = 200;
    localparam int N_DIRECTED = 18;
    localparam logic signed [AUTO_W-1:0] CMAX = 32'sh7FFF_FFFF;
    localparam logic signed [AUTO_W-1:0] CMIN = 32'sh8000_0000;
    localparam logic signed [STEER_W-1:0] QP = 16'sd16384;
    localparam logic signed [STEER_W-1:0] QN = -16'sd16384;
    localparam bin_result_t UNTYPED = '0;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [AUTO_W-1:0]  auto_first_re;
    logic signed [AUTO_W-1:0]  auto_second_re;
    logic signed [AUTO_W-1:0]  cross_re;
    logic signed [AUTO_W-1:0]  cross_im;
    logic signed [STEER_W-1:0] steer_re;
    logic signed [STEER_W-1:0] steer_im;
    logic signed [STEER_W-1:0] coherence;
    logic                      last_pair;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [SUM_W-1:0]   spectrum;
    logic                      divide_by_zero;
    logic                      saturated;

    pair_coherence_spatial_spectrum dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .auto_first_re  (auto_first_re),
        .auto_second_re (auto_second_re),
        .cross_re       (cross_re),
        .cross_im       (cross_im),
        .steer_re       (steer_re),
        .steer_im       (steer_im),
        .coherence      (coherence),
        .last_pair      (last_pair),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .spectrum       (spectrum),
        .divide_by_zero (divide_by_zero),
        .saturated      (saturated)
    );

    longint      bin_sum;
    bit          bin_zero_div;
    bit          bin_sat;
    bin_result_t spectrum_queue[$];
    int          items_sent;
    int          sums_checked;
    int          sums_zero_div;
    int          sums_sat;
    int          error_count;
    int          send_gap_pct;
    int          recv_gap_pct;

    directed_row_t directed_rows [N_DIRECTED] = '{
        '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1},
          1'b1, '{SUM_MAX, 1'b1, 1'b1}},
        '{'{32'sd65536, 32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, QP, 1'b1},
          1'b1, '{-40'sd65536, 1'b0, 1'b0}},
        '{'{32'sd65536, 32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, QN, 1'b1},
          1'b1, '{40'sd65536, 1'b0, 1'b0}},
        '{'{-32'sd32768, -32'sd32768, -32'sd32768, 32'sd0, QP, 16'sd0, 16'sd0, 1'b1},
          1'b1, '{SUM_MIN, 1'b1, 1'b1}},
        '{'{32'sd65536, 32'sd65536, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1},
          1'b1, '{40'sd0, 1'b0, 1'b0}},
        '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
          1'b0, UNTYPED},
        '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1},
          1'b1, '{SUM_MAX, 1'b1, 1'b1}},
        '{'{CMAX, CMAX, CMAX, CMIN, QP, QN, QP, 1'b1}, 1'b0, UNTYPED},
        '{'{CMIN, CMIN, CMIN, CMAX, QN, QP, QN, 1'b1}, 1'b0, UNTYPED},
        '{'{32'sd1, 32'sd0, CMAX, CMAX, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1},
          1'b0, UNTYPED},
        '{'{CMAX, CMIN, CMIN, CMIN, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b1},
          1'b0, UNTYPED},
        '{'{32'sd1073741825, 32'sd0, 32'sd536870912, 32'sd0, QP, 16'sd0, 16'sh8000, 1'b1},
          1'b0, UNTYPED},
        '{'{32'sd65536, 32'sd0, -32'sd1, 32'sd0, 16'sd1, 16'sd0, 16'sd0, 1'b1},
          1'b0, UNTYPED},
        '{'{32'sd100000, -32'sd300000, 32'sd12345, -32'sd6789, 16'sd11585, -16'sd11585,
            16'sd5000, 1'b1}, 1'b0, UNTYPED},
        '{'{32'sd300000, 32'sd250000, 32'sd120000, -32'sd40000, 16'sd11585, 16'sd11585,
            16'sd3000, 1'b0}, 1'b0, UNTYPED},
        '{'{32'sd500000, 32'sd480000, -32'sd200000, 32'sd90000, QN, 16'sd0,
            16'sd12000, 1'b0}, 1'b0, UNTYPED},
        '{'{32'sd70000, 32'sd90000, 32'sd1000, 32'sd2000, 16'sd0, QP,
            -16'sd2000, 1'b0}, 1'b0, UNTYPED},
        '{'{32'sd1000000, 32'sd900000, 32'sd800000, 32'sd100000, 16'sd15000, -16'sd6000,
            QP, 1'b1}, 1'b0, UNTYPED}
    };

    function automatic longint clamp_sum(input longint v, inout bit clipped);
        if (v > longint'(SUM_MAX))
        begin
            clipped = 1'b1;
            return longint'(SUM_MAX);
        end
        if (v < longint'(SUM_MIN))
        begin
            clipped = 1'b1;
            return longint'(SUM_MIN);
        end
        return v;
    endfunction

    function automatic bit accumulate_pair(input pair_item_t it, output bin_result_t res);
        longint tr;
        longint prod;
        longint t;
        longint num;
        longint den;
        longint top;
        longint term;
        longint one;
        bit     clipped;
        one = longint'(Q14_ONE);
        clipped = 1'b0;
        tr = longint'(it.auto_first_re) + longint'(it.auto_second_re);
        prod = longint'(it.cross_re) * longint'(it.steer_re)
             - longint'(it.cross_im) * longint'(it.steer_im);
        t = prod >>> 14;
        num = tr + 2 * t;
        den = tr - 2 * t;
        top = 2 * (one - longint'(it.coherence)) * num;
        if (den == 0)
        begin
            term = (top >= 0) ? longint'(SUM_MAX) : longint'(SUM_MIN);
            bin_zero_div = 1'b1;
            bin_sat = 1'b1;
        end
        else
        begin
            term = clamp_sum(top / den - 2 * (one + longint'(it.coherence)), clipped);
        end
        bin_sum = clamp_sum(bin_sum + term, clipped);
        if (clipped)
        begin
            bin_sat = 1'b1;
        end
        res.spectrum = bin_sum[SUM_W-1:0];
        res.divide_by_zero = bin_zero_div;
        res.saturated = bin_sat;
        if (it.last_pair)
        begin
            bin_sum = 0;
            bin_zero_div = 1'b0;
            bin_sat = 1'b0;
        end
        return it.last_pair;
    endfunction

    function automatic logic signed [AUTO_W-1:0] pick_cov(input int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 1 << 24);
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return CMAX;
                    1: return CMIN;
                    2: return -32'sd1;
                    3: return 32'sd1;
                    default: return 32'sd0;
                endcase
            end
            default: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        endcase
    endfunction

    function automatic logic signed [STEER_W-1:0] pick_q14(input int mode);
        int v;
        case (mode)
            0: return STEER_W'($urandom);
            1:
            begin
                v = $urandom_range(0, 32768);
                return STEER_W'(v - 16384);
            end
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return QP;
                    1: return QN;
                    2: return 16'sh7FFF;
                    3: return 16'sh8000;
                    default: return 16'sd0;
                endcase
            end
        endcase
    endfunction

    task automatic send_pair(input pair_item_t it, input bit typed, input bin_result_t want);
        bin_result_t res;
        if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        auto_first_re  <= it.auto_first_re;
        auto_second_re <= it.auto_second_re;
        cross_re       <= it.cross_re;
        cross_im       <= it.cross_im;
        steer_re       <= it.steer_re;
        steer_im       <= it.steer_im;
        coherence      <= it.coherence;
        last_pair      <= it.last_pair;
        do @(posedge clk); while (in_stall);
        if (accumulate_pair(it, res))
        begin
            spectrum_queue.push_back(typed ? want : res);
        end
        items_sent++;
    endtask

    task automatic note_error(input string what, input bin_result_t want, input bin_result_t got);
        error_count++;
        if (error_count <= 10)
        begin
            $display("%s: expected spectrum=%0d dz=%0b sat=%0b, got spectrum=%0d dz=%0b sat=%0b",
                     what, want.spectrum, want.divide_by_zero, want.saturated,
                     got.spectrum, got.divide_by_zero, got.saturated);
        end
    endtask

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("tb_pair_coherence_spatial_spectrum: done, errors");
        $finish;
    end

    initial
    begin
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (recv_gap_pct != 0 && $urandom_range(0, 99) < recv_gap_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        bin_result_t want;
        bin_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{spectrum, divide_by_zero, saturated};
            sums_checked++;
            if (divide_by_zero)
            begin
                sums_zero_div++;
            end
            if (saturated)
            begin
                sums_sat++;
            end
            if (spectrum_queue.size() == 0)
            begin
                note_error("unexpected bin sum", UNTYPED, got);
            end
            else
            begin
                want = spectrum_queue.pop_front();
                if (got !== want)
                begin
                    note_error("bin sum mismatch", want, got);
                end
            end
        end
    end

    initial
    begin
        pair_item_t it;
        int         k;
        int         bin_len;
        int         style;
        int         next_phase;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        auto_first_re  = '0;
        auto_second_re = '0;
        cross_re       = '0;
        cross_im       = '0;
        steer_re       = '0;
        steer_im       = '0;
        coherence      = '0;
        last_pair      = 1'b0;
        bin_sum        = 0;
        bin_zero_div   = 1'b0;
        bin_sat        = 1'b0;
        items_sent     = 0;
        sums_checked   = 0;
        sums_zero_div  = 0;
        sums_sat       = 0;
        error_count    = 0;
        send_gap_pct   = 20;
        recv_gap_pct   = 20;
        next_phase     = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < N_DIRECTED; k++)
        begin
            send_pair(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);
        end

        while (items_sent < N_TOTAL)
        begin
            if (items_sent >= N_TOTAL - QUIET_TAIL)
            begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            else if (items_sent >= next_phase)
            begin
                next_phase = items_sent + 150;
                case ($urandom_range(0, 3))
                    0: send_gap_pct = 0;
                    1: send_gap_pct = 10;
                    2: send_gap_pct = 25;
                    default: send_gap_pct = 50;
                endcase
                case ($urandom_range(0, 3))
                    0: recv_gap_pct = 0;
                    1: recv_gap_pct = 10;
                    2: recv_gap_pct = 25;
                    default: recv_gap_pct = 50;
                endcase
            end
            if ($urandom_range(0, 9) == 0)
            begin
                it.auto_first_re  = $urandom;
                it.auto_second_re = $urandom;
                it.cross_re       = $urandom;
                it.cross_im       = $urandom;
                it.steer_re       = STEER_W'($urandom);
                it.steer_im       = STEER_W'($urandom);
                it.coherence      = STEER_W'($urandom);
                it.last_pair      = 1'($urandom_range(0, 1));
                send_pair(it, 1'b0, UNTYPED);
            end
            else
            begin
                bin_len = $urandom_range(1, 8);
                style = $urandom_range(0, 2);
                for (k = 0; k < bin_len; k++)
                begin
                    if (style == 0)
                    begin
                        it.auto_first_re  = pick_cov(1);
                        it.auto_second_re = pick_cov(1);
                        it.cross_re       = pick_cov(3);
                        it.cross_im       = pick_cov(3);
                        it.steer_re       = pick_q14(1);
                        it.steer_im       = pick_q14(1);
                        it.coherence      = pick_q14(1);
                    end
                    else
                    begin
                        it.auto_first_re  = pick_cov($urandom_range(0, 3));
                        it.auto_second_re = pick_cov($urandom_range(0, 3));
                        it.cross_re       = pick_cov($urandom_range(0, 3));
                        it.cross_im       = pick_cov($urandom_range(0, 3));
                        it.steer_re       = pick_q14($urandom_range(0, 2));
                        it.steer_im       = pick_q14($urandom_range(0, 2));
                        it.coherence      = pick_q14($urandom_range(0, 2));
                    end
                    // With a purely real unit steering term and a trace of twice the
                    // cross real part, the divisor of the ratio is exactly zero.
                    if ($urandom_range(0, 11) == 0)
                    begin
                        it.cross_re       = pick_cov($urandom_range(0, 3));
                        it.auto_first_re  = it.cross_re;
                        it.auto_second_re = it.cross_re;
                        it.steer_re       = QP;
                        it.steer_im       = 16'sd0;
                    end
                    it.last_pair = (k == bin_len - 1);
                    send_pair(it, 1'b0, UNTYPED);
                end
            end
        end
        in_valid <= 1'b0;

        while (spectrum_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);

        $display("Sent %0d pair items; checked %0d bin sums", items_sent, sums_checked);
        $display("(%0d with a zero divisor, %0d saturated); mismatches and unexpected sums: %0d.",
                 sums_zero_div, sums_sat, error_count);
        if (error_count == 0)
        begin
            $display("tb_pair_coherence_spatial_spectrum: done, clean");
        end
        else
        begin
            $display("tb_pair_coherence_spatial_spectrum: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/pcs_pkg.sv
hw/rtl/pcs_mul.sv
hw/rtl/pcs_div.sv
hw/rtl/pair_coherence_spatial_spectrum.sv
verif/tb_pair_coherence_spatial_spectrum.sv
